>>> rtl/core/fela_pkg.sv
// ----------------------------------------------------------------------------
// fela_pkg: shared types and constants of the free-list slot allocator
// Status codes, register indexes, stream packing, controller/datapath links.
// ----------------------------------------------------------------------------
package fela_pkg;

  // Default sizing
  localparam int MAX_SLOTS_DEF   = 256;
  localparam int OFFSET_BITS_DEF = 24;

  // Stack entries hold an 8-bit slot index
  localparam int ENTRY_W = 8;

  // Field widths
  localparam int SIZE_W   = 16;
  localparam int COUNT_W  = 9;
  localparam int OFF_W    = 24;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 8;

  // Stream widths
  localparam int S_TDATA_W = 40;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 48;
  localparam int M_TUSER_W = 1;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_SIZE        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_COUNT       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OVERFLOW_SIZE_LIMIT = 2'd2;

  // Reset values of the registers
  localparam logic [SIZE_W-1:0]  ELEMENT_SIZE_RST  = 16'd8;
  localparam logic [COUNT_W-1:0] ELEMENT_COUNT_RST = 9'd256;
  localparam logic [SIZE_W-1:0]  OVF_LIMIT_RST     = 16'd256;

  // Offset divider: slot size is a multiple of 8, so divide offset/8 by size/8
  localparam int DVD_W     = OFF_W - 3;
  localparam int DIVISOR_W = SIZE_W + 1 - 3;
  localparam int DIV_STEPS = DVD_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Action codes
  localparam logic ACTION_ALLOC = 1'b0;
  localparam logic ACTION_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK          = 3'd0,
    STATUS_POOL_EMPTY  = 3'd1,
    STATUS_OVF_BUSY    = 3'd2,
    STATUS_OVF_TOO_BIG = 3'd3,
    STATUS_STACK_FULL  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_READ,
    ST_MUL,
    ST_DIVIDE,
    ST_PUSH,
    ST_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic    load_item;
    logic    set_status;
    status_t status_code;
    logic    take_ovf;
    logic    release_ovf;
    logic    pop;
    logic    capture_idx;
    logic    mul;
    logic    div_start;
    logic    div_step;
    logic    push;
    logic    emit;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_free;
    logic is_odd;
    logic ovf_taken;
    logic too_big;
    logic pool_empty;
    logic free_ovf;
    logic stack_full;
    logic div_last;
    logic out_free;
  } dp_status_t;

endpackage

>>> rtl/core/fela_ram.sv
// ----------------------------------------------------------------------------
// fela_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module fela_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/fela_datapath.sv
// ----------------------------------------------------------------------------
// fela_datapath: registers, free stack, multiplier and offset divider
// Executes the controller's commands and reports condition flags.
// ----------------------------------------------------------------------------
module fela_datapath #(
  parameter int MAX_SLOTS   = fela_pkg::MAX_SLOTS_DEF,
  parameter int OFFSET_BITS = fela_pkg::OFFSET_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_valid,
  input  logic [fela_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fela_pkg::CFG_DATA_W-1:0]     cfg_data,
  // input item
  input  logic [fela_pkg::S_TDATA_W-1:0]      s_tdata,
  input  logic [fela_pkg::S_TUSER_W-1:0]      s_tuser,
  // result item
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [fela_pkg::M_TDATA_W-1:0]      m_tdata,
  output logic [fela_pkg::M_TUSER_W-1:0]      m_tuser,
  // control
  input  fela_pkg::ctl_cmd_t                  cmd,
  output fela_pkg::dp_status_t                stat
);

  localparam int IDX_W = $clog2(MAX_SLOTS);
  localparam int CNT_W = $clog2(MAX_SLOTS + 1);
  localparam logic [31:0] OFF_MASK = 32'((64'd1 << OFFSET_BITS) - 64'd1);

  // Configuration registers
  logic [fela_pkg::SIZE_W-1:0]  element_size;
  logic [fela_pkg::COUNT_W-1:0] element_count;
  logic [fela_pkg::SIZE_W-1:0]  ovf_limit;

  // Allocator state
  logic [CNT_W-1:0] free_count;
  logic [CNT_W-1:0] low_mark;   // lowest stack position written since refill
  logic             ovf_taken;

  // Latched item
  logic                         item_action;
  logic                         item_is_ovf;
  logic [fela_pkg::SIZE_W-1:0]  item_req;
  logic [fela_pkg::OFF_W-1:0]   item_offset;

  // Result fields
  fela_pkg::status_t            res_status;
  logic [fela_pkg::SLOT_W-1:0]  res_index;
  logic [fela_pkg::OFF_W-1:0]   res_offset;
  logic                         res_ovf;

  // Divider
  logic [fela_pkg::DVD_W-1:0]     div_dvd;
  logic [fela_pkg::DIVISOR_W-1:0] div_rem;
  logic [fela_pkg::ENTRY_W-1:0]   div_q;
  logic [fela_pkg::DIV_CNT_W-1:0] div_cnt;
  logic [fela_pkg::DIVISOR_W:0]   div_trial;
  logic                           div_fits;

  // Derived values
  logic [fela_pkg::SIZE_W:0]      size_plus;
  logic [fela_pkg::DIVISOR_W-1:0] size_units;
  logic [fela_pkg::SIZE_W:0]      rounded;
  logic [CNT_W-1:0]               cap;
  logic [CNT_W-1:0]               cap_new;
  logic [24:0]                    product;
  logic [31:0]                    product_masked;

  // Stack memory
  logic [IDX_W-1:0]             ram_waddr;
  logic [IDX_W-1:0]             ram_raddr;
  logic [fela_pkg::ENTRY_W-1:0] ram_wdata;
  logic [fela_pkg::ENTRY_W-1:0] ram_rdata;

  // Slot size rounded up to a multiple of 8
  assign size_plus  = {1'b0, element_size} + 17'd7;
  assign size_units = size_plus[fela_pkg::SIZE_W:3];
  assign rounded    = {size_units, 3'b000};

  // Capacity: element_count clamped to the stack depth
  assign cap     = (32'(element_count) > 32'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS)
                                                        : CNT_W'(element_count);
  assign cap_new = (32'(cfg_data[fela_pkg::COUNT_W-1:0]) > 32'(MAX_SLOTS)) ?
                   CNT_W'(MAX_SLOTS) : CNT_W'(cfg_data[fela_pkg::COUNT_W-1:0]);

  // Slot offset product
  assign product        = 25'(res_index) * 25'(rounded);
  assign product_masked = 32'(product) & OFF_MASK;

  // Restoring divider step
  assign div_trial = {div_rem, div_dvd[fela_pkg::DVD_W-1]};
  assign div_fits  = div_trial >= {1'b0, size_units};

  // Stack memory ports
  assign ram_raddr = IDX_W'(free_count - CNT_W'(1));
  assign ram_waddr = IDX_W'(free_count);
  assign ram_wdata = (size_units == '0) ? '1 : div_q;

  fela_ram #(
    .WIDTH (fela_pkg::ENTRY_W),
    .DEPTH (MAX_SLOTS)
  ) u_stack (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      element_size  <= fela_pkg::ELEMENT_SIZE_RST;
      element_count <= fela_pkg::ELEMENT_COUNT_RST;
      ovf_limit     <= fela_pkg::OVF_LIMIT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        fela_pkg::REG_ELEMENT_SIZE:        element_size  <= cfg_data;
        fela_pkg::REG_ELEMENT_COUNT:       element_count <= cfg_data[fela_pkg::COUNT_W-1:0];
        fela_pkg::REG_OVERFLOW_SIZE_LIMIT: ovf_limit     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Free count, low mark and overflow flag; a count write refills the stack
  always_ff @(posedge clk) begin
    if (rst) begin
      free_count <= (32'(fela_pkg::ELEMENT_COUNT_RST) > 32'(MAX_SLOTS)) ?
                    CNT_W'(MAX_SLOTS) : CNT_W'(fela_pkg::ELEMENT_COUNT_RST);
      low_mark   <= CNT_W'(MAX_SLOTS);
      ovf_taken  <= 1'b0;
    end else if (cfg_valid && cfg_index == fela_pkg::REG_ELEMENT_COUNT) begin
      free_count <= cap_new;
      low_mark   <= CNT_W'(MAX_SLOTS);
      ovf_taken  <= 1'b0;
    end else begin
      if (cmd.pop) begin
        free_count <= free_count - CNT_W'(1);
      end else if (cmd.push) begin
        free_count <= free_count + CNT_W'(1);
        if (free_count < low_mark) begin
          low_mark <= free_count;
        end
      end
      if (cmd.take_ovf) begin
        ovf_taken <= 1'b1;
      end else if (cmd.release_ovf) begin
        ovf_taken <= 1'b0;
      end
    end
  end

  // Item capture and result fields
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_req    <= s_tdata[15:0];
      item_offset <= s_tdata[39:16];
      item_action <= s_tuser[0];
      item_is_ovf <= s_tuser[1];
      res_status  <= fela_pkg::STATUS_OK;
      res_index   <= '0;
      res_offset  <= '0;
      res_ovf     <= 1'b0;
    end else begin
      if (cmd.set_status) begin
        res_status <= cmd.status_code;
      end
      if (cmd.take_ovf) begin
        res_ovf <= 1'b1;
      end
      // Positions at or above the low mark hold pushed data; below it, reset data
      if (cmd.capture_idx) begin
        res_index <= (free_count >= low_mark) ? ram_rdata
                                              : fela_pkg::ENTRY_W'(free_count);
      end
      if (cmd.mul) begin
        res_offset <= product_masked[fela_pkg::OFF_W-1:0];
      end
    end
  end

  // Offset divider: one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_dvd <= item_offset[fela_pkg::OFF_W-1:3];
      div_rem <= '0;
      div_q   <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_dvd <= {div_dvd[fela_pkg::DVD_W-2:0], 1'b0};
      div_rem <= div_fits ? fela_pkg::DIVISOR_W'(div_trial - {1'b0, size_units})
                          : div_trial[fela_pkg::DIVISOR_W-1:0];
      div_q   <= {div_q[fela_pkg::ENTRY_W-2:0], div_fits};
      div_cnt <= div_cnt + fela_pkg::DIV_CNT_W'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= {4'b0000, fela_pkg::COUNT_W'(free_count), res_offset, res_index,
                  res_status};
      m_tuser <= res_ovf;
    end
  end

  // Condition flags
  always_comb begin
    stat.is_free    = item_action == fela_pkg::ACTION_FREE;
    stat.is_odd     = item_req != element_size;
    stat.ovf_taken  = ovf_taken;
    stat.too_big    = item_req >= ovf_limit;
    stat.pool_empty = free_count == '0;
    stat.free_ovf   = item_is_ovf;
    stat.stack_full = free_count >= cap;
    stat.div_last   = div_cnt == fela_pkg::DIV_CNT_W'(fela_pkg::DIV_STEPS - 1);
    stat.out_free   = !m_tvalid || m_tready;
  end

endmodule

>>> rtl/core/fela_ctrl.sv
// ----------------------------------------------------------------------------
// fela_ctrl: allocator sequencer
// Walks each item through decide, then stack read and multiply or divide and stack push, then emit.
// ----------------------------------------------------------------------------
module fela_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  fela_pkg::dp_status_t  stat,
  output fela_pkg::ctl_cmd_t    cmd
);

  fela_pkg::state_t state;
  fela_pkg::state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fela_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      fela_pkg::ST_IDLE: begin
        if (s_tvalid) state_next = fela_pkg::ST_DISPATCH;
      end
      fela_pkg::ST_DISPATCH: begin
        if (!stat.is_free) begin
          if (stat.is_odd || stat.pool_empty) state_next = fela_pkg::ST_DONE;
          else                                state_next = fela_pkg::ST_READ;
        end else begin
          if (stat.free_ovf || stat.stack_full) state_next = fela_pkg::ST_DONE;
          else                                  state_next = fela_pkg::ST_DIVIDE;
        end
      end
      fela_pkg::ST_READ:   state_next = fela_pkg::ST_MUL;
      fela_pkg::ST_MUL:    state_next = fela_pkg::ST_DONE;
      fela_pkg::ST_DIVIDE: begin
        if (stat.div_last) state_next = fela_pkg::ST_PUSH;
      end
      fela_pkg::ST_PUSH:   state_next = fela_pkg::ST_DONE;
      fela_pkg::ST_DONE: begin
        if (stat.out_free) state_next = fela_pkg::ST_IDLE;
      end
      default:             state_next = fela_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    case (state)
      fela_pkg::ST_IDLE: begin
        // hold off items while in reset
        s_tready      = !rst;
        cmd.load_item = s_tvalid && !rst;
      end
      fela_pkg::ST_DISPATCH: begin
        if (!stat.is_free) begin
          if (stat.is_odd) begin
            // odd size goes to the overflow buffer
            if (stat.ovf_taken) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = fela_pkg::STATUS_OVF_BUSY;
            end else if (stat.too_big) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = fela_pkg::STATUS_OVF_TOO_BIG;
            end else begin
              cmd.take_ovf = 1'b1;
            end
          end else if (stat.pool_empty) begin
            cmd.set_status  = 1'b1;
            cmd.status_code = fela_pkg::STATUS_POOL_EMPTY;
          end else begin
            cmd.pop = 1'b1;
          end
        end else begin
          if (stat.free_ovf) begin
            cmd.release_ovf = 1'b1;
          end else if (stat.stack_full) begin
            cmd.set_status  = 1'b1;
            cmd.status_code = fela_pkg::STATUS_STACK_FULL;
          end else begin
            cmd.div_start = 1'b1;
          end
        end
      end
      fela_pkg::ST_READ:   cmd.capture_idx = 1'b1;
      fela_pkg::ST_MUL:    cmd.mul = 1'b1;
      fela_pkg::ST_DIVIDE: cmd.div_step = 1'b1;
      fela_pkg::ST_PUSH:   cmd.push = 1'b1;
      fela_pkg::ST_DONE:   cmd.emit = stat.out_free;
      default: ;
    endcase
  end

endmodule

>>> rtl/core/fixed_element_free_list_allocator_core.sv
// Sequence: overflow alloc/free and failed requests: dispatch, then result emit.
// Slot alloc: dispatch, stack read, then offset multiply, then emit.
// Slot free: dispatch, the 21-step offset divider (one quotient bit a cycle), then stack push.
// Throughput: one item at a time; the next item is taken once the result is in the
// output register.
// Reset: synchronous; registers to defaults, stack full with 0..count-1, no clear pass.
// ----------------------------------------------------------------------------
// fixed_element_free_list_allocator_core: fixed-size slot pool allocator
// Free-list stack of slot indices plus one overflow buffer for odd sizes.
// ----------------------------------------------------------------------------
module fixed_element_free_list_allocator_core #(
  parameter int MAX_SLOTS   = fela_pkg::MAX_SLOTS_DEF,
  parameter int OFFSET_BITS = fela_pkg::OFFSET_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration write
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fela_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fela_pkg::CFG_DATA_W-1:0] cfg_data,
  // request stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [fela_pkg::S_TDATA_W-1:0]  s_tdata,   // request_size, free_byte_offset
  input  logic [fela_pkg::S_TUSER_W-1:0]  s_tuser,   // action, free_is_overflow
  // result stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [fela_pkg::M_TDATA_W-1:0]  m_tdata,   // status, slot_index,
                                                     // slot_byte_offset, free_remaining
  output logic [fela_pkg::M_TUSER_W-1:0]  m_tuser    // got_overflow
);

  fela_pkg::ctl_cmd_t   cmd;
  fela_pkg::dp_status_t stat;

  // Take register writes at once; the host must issue them only between items (not enforced here)
  assign cfg_ready = 1'b1;

  fela_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fela_datapath #(
    .MAX_SLOTS   (MAX_SLOTS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

>>> rtl/core/fela_checker.sv
// ----------------------------------------------------------------------------
// fela_checker: port-level checks of the slot allocator
// Watches the request and result streams over time.
// ----------------------------------------------------------------------------
module fela_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [fela_pkg::M_TDATA_W-1:0] m_tdata,
  input logic [fela_pkg::M_TUSER_W-1:0] m_tuser
);

  // One item in flight: no second accept right after one
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request accepted back to back");

  // Held result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

  // Overflow grant is a success with no slot
  a_ovf_grant: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |->
      (m_tdata[2:0] == fela_pkg::STATUS_OK && m_tdata[10:3] == 8'd0 &&
       m_tdata[34:11] == 24'd0))
    else $error("overflow grant carries slot data");

  // Empty pool is reported only with no free slot left
  a_empty: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[2:0] == fela_pkg::STATUS_POOL_EMPTY) |->
      (m_tdata[43:35] == 9'd0))
    else $error("pool empty with free slots");

endmodule

bind fixed_element_free_list_allocator_core fela_checker u_fela_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the fixed-element free-list slot allocator
// A short table of directed requests and register writes runs first. Random
// phases follow, each under its own pool configuration. Every result item is
// checked field by field against its table row or a local copy of the free stack,
// slot counter and overflow flag, kept in step with each accepted request.
// ----------------------------------------------------------------------------
module tb_top;
  import fela_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RST_CYCLES   = 6;
  localparam int RANDOM_ITEMS = 1450;
  localparam int PHASES       = 6;
  localparam int IDLE_PCT     = 12;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 600000;

  typedef struct packed {
    logic              action;
    logic [SIZE_W-1:0] size;
    logic              is_ovf;
    logic [OFF_W-1:0]  off;
  } request_t;

  typedef struct packed {
    status_t            status;
    logic [SLOT_W-1:0]  slot;
    logic [OFF_W-1:0]   boff;
    logic               got_ovf;
    logic [COUNT_W-1:0] remain;
  } response_t;

  typedef struct packed {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    request_t              req;
    logic                  typed;
    response_t             exp;
  } step_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata = '0;
  logic [S_TUSER_W-1:0]  s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic [M_TUSER_W-1:0]  m_tuser;

  // Local copy of the allocator state and registers
  logic [ENTRY_W-1:0] free_stack [MAX_SLOTS_DEF];
  logic [COUNT_W-1:0] free_cnt;
  logic               ovf_busy;
  logic [SIZE_W-1:0]  elem_size;
  logic [COUNT_W-1:0] elem_count;
  logic [SIZE_W-1:0]  ovf_limit;

  response_t   pending_results [$];
  step_row_t   directed_rows [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  logic        no_idle = 1'b0;
  logic        drain_mode = 1'b1;

  fixed_element_free_list_allocator_core dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #CLK_HALF clk = ~clk;

  // Slot size rounded up to a multiple of 8
  function automatic int unsigned slot_bytes();
    int unsigned sz;
    sz = elem_size;
    return (sz + 7) / 8 * 8;
  endfunction

  function automatic logic [COUNT_W-1:0] pool_capacity();
    return (elem_count > MAX_SLOTS_DEF) ? COUNT_W'(MAX_SLOTS_DEF) : elem_count;
  endfunction

  // Refill the stack with 0..count-1 and release the overflow buffer
  function automatic void refill_pool();
    for (int i = 0; i < MAX_SLOTS_DEF; i++) free_stack[i] = ENTRY_W'(i);
    free_cnt = pool_capacity();
    ovf_busy = 1'b0;
  endfunction

  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_ELEMENT_SIZE:        elem_size = val;
      REG_ELEMENT_COUNT: begin
        elem_count = val[COUNT_W-1:0];
        refill_pool();
      end
      REG_OVERFLOW_SIZE_LIMIT: ovf_limit = val;
      default: ;
    endcase
  endfunction

  // Advance the local allocator state by one request and return its result
  function automatic response_t allocator_step(request_t r);
    response_t          o;
    int unsigned        rs;
    int unsigned        quo;
    int unsigned        prod;
    logic [ENTRY_W-1:0] idx;
    o = '0;
    o.status = STATUS_OK;
    rs = slot_bytes();
    if (r.action == ACTION_ALLOC) begin
      if (r.size != elem_size) begin
        if (ovf_busy) begin
          o.status = STATUS_OVF_BUSY;
        end else if (r.size >= ovf_limit) begin
          o.status = STATUS_OVF_TOO_BIG;
        end else begin
          ovf_busy = 1'b1;
          o.got_ovf = 1'b1;
        end
      end else if (free_cnt == 0) begin
        o.status = STATUS_POOL_EMPTY;
      end else begin
        free_cnt = free_cnt - 1'b1;
        idx = free_stack[free_cnt[ENTRY_W-1:0]];
        prod = idx * rs;
        o.slot = idx;
        o.boff = prod[OFF_W-1:0];
      end
    end else begin
      if (r.is_ovf) begin
        ovf_busy = 1'b0;
      end else if (free_cnt >= pool_capacity()) begin
        o.status = STATUS_STACK_FULL;
      end else begin
        // A zero slot size gives the all-ones quotient
        quo = (rs == 0) ? 32'hFFFF_FFFF : r.off / rs;
        free_stack[free_cnt[ENTRY_W-1:0]] = quo[ENTRY_W-1:0];
        free_cnt = free_cnt + 1'b1;
      end
    end
    o.remain = free_cnt;
    return o;
  endfunction

  // Build a mostly well-formed request that keeps draining and refilling the pool
  function automatic request_t random_request();
    request_t           r;
    int unsigned        rs;
    int unsigned        pick;
    int unsigned        idx;
    logic [COUNT_W-1:0] cap;
    rs = slot_bytes();
    cap = pool_capacity();
    if ((free_cnt == 0 || free_cnt >= cap) && $urandom_range(0, 3) == 0) begin
      drain_mode = (free_cnt != 0);
    end else if ($urandom_range(0, 99) == 0) begin
      drain_mode = !drain_mode;
    end
    r.action = 1'($urandom);
    r.size = 16'($urandom);
    r.is_ovf = 1'($urandom);
    r.off = 24'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      // keep the fully random noise item
    end else if (pick < 22) begin
      r.action = ACTION_ALLOC;
      if ($urandom_range(0, 3) != 0) r.size = 16'($urandom_range(0, ovf_limit));
    end else if (pick < 30) begin
      r.action = ACTION_FREE;
      r.is_ovf = 1'b1;
    end else if (pick < (drain_mode ? 85 : 45)) begin
      r.action = ACTION_ALLOC;
      r.size = elem_size;
    end else begin
      r.action = ACTION_FREE;
      r.is_ovf = 1'b0;
      idx = $urandom_range(0, (cap == 0) ? 0 : cap - 1);
      if (rs != 0) r.off = 24'(idx * rs + ($urandom % rs));
    end
    return r;
  endfunction

  function automatic void add_setting(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    step_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_request(logic act, logic [SIZE_W-1:0] size, logic ovf,
                                      logic [OFF_W-1:0] off);
    step_row_t row;
    row = '0;
    row.req = '{action: act, size: size, is_ovf: ovf, off: off};
    directed_rows.push_back(row);
  endfunction

  function automatic void add_expected(logic act, logic [SIZE_W-1:0] size, logic ovf,
                                       logic [OFF_W-1:0] off, status_t st,
                                       logic [SLOT_W-1:0] slot, logic [OFF_W-1:0] boff,
                                       logic gov, logic [COUNT_W-1:0] remain);
    step_row_t row;
    row = '0;
    row.req = '{action: act, size: size, is_ovf: ovf, off: off};
    row.typed = 1'b1;
    row.exp = '{status: st, slot: slot, boff: boff, got_ovf: gov, remain: remain};
    directed_rows.push_back(row);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("MISMATCH %s: expected %0d, got %0d (cycle %0d)", what, want, got, cycle_count);
    mismatch_count++;
  endtask

  // Drive one request item, hold it until accepted, then record its result
  task automatic send_request(input request_t r, input logic typed, input response_t exp);
    response_t pred;
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = {r.off, r.size};
    s_tuser = {r.is_ovf, r.action};
    do @(posedge clk); while (!s_tready);
    pred = allocator_step(r);
    pending_results.push_back(typed ? exp : pred);
    @(negedge clk);
  endtask

  // Write one register once the block has gone quiet
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    s_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    apply_register(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Stall the result side at random, except while no_idle is set
  always @(negedge clk) begin
    m_tready = no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Compare each result item with the oldest pending result
  always @(posedge clk) begin : check_results
    response_t got;
    response_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[2:0], m_tdata[10:3], m_tdata[34:11], m_tuser[0], m_tdata[43:35]};
      if (pending_results.size() == 0) begin
        report_mismatch("result item with none pending", 0, 1);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status) report_mismatch("status", want.status, got.status);
        if (got.slot !== want.slot) report_mismatch("slot_index", want.slot, got.slot);
        if (got.boff !== want.boff) report_mismatch("slot_byte_offset", want.boff, got.boff);
        if (got.got_ovf !== want.got_ovf) report_mismatch("got_overflow", want.got_ovf, got.got_ovf);
        if (got.remain !== want.remain) report_mismatch("free_remaining", want.remain, got.remain);
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    logic [SIZE_W-1:0]  sz;
    logic [COUNT_W-1:0] cnt;
    logic [SIZE_W-1:0]  lim;
    elem_size = ELEMENT_SIZE_RST;
    elem_count = ELEMENT_COUNT_RST;
    ovf_limit = OVF_LIMIT_RST;
    refill_pool();

    // Defaults after reset: size 8, 256 slots, overflow limit 256
    add_expected(ACTION_ALLOC, 16'd8, 1'b0, 24'd0, STATUS_OK, 8'd255, 24'd2040, 1'b0, 9'd255);
    add_expected(ACTION_ALLOC, 16'd0, 1'b0, 24'd0, STATUS_OK, 8'd0, 24'd0, 1'b1, 9'd255);
    add_expected(ACTION_ALLOC, 16'd100, 1'b0, 24'd0, STATUS_OVF_BUSY, 8'd0, 24'd0, 1'b0, 9'd255);
    add_expected(ACTION_FREE, 16'd0, 1'b1, 24'd0, STATUS_OK, 8'd0, 24'd0, 1'b0, 9'd255);
    // release of an overflow buffer that is not taken
    add_expected(ACTION_FREE, 16'hFFFF, 1'b1, 24'hFFFFFF, STATUS_OK, 8'd0, 24'd0, 1'b0, 9'd255);
    add_expected(ACTION_ALLOC, 16'd256, 1'b0, 24'd0, STATUS_OVF_TOO_BIG, 8'd0, 24'd0, 1'b0, 9'd255);
    add_expected(ACTION_ALLOC, 16'hFFFF, 1'b1, 24'hFFFFFF, STATUS_OVF_TOO_BIG, 8'd0, 24'd0,
                 1'b0, 9'd255);
    add_expected(ACTION_ALLOC, 16'd255, 1'b0, 24'd0, STATUS_OK, 8'd0, 24'd0, 1'b1, 9'd255);
    add_expected(ACTION_FREE, 16'd0, 1'b0, 24'd2040, STATUS_OK, 8'd0, 24'd0, 1'b0, 9'd256);
    // frees onto a full stack
    add_expected(ACTION_FREE, 16'd0, 1'b0, 24'd0, STATUS_STACK_FULL, 8'd0, 24'd0, 1'b0, 9'd256);
    add_expected(ACTION_FREE, 16'hFFFF, 1'b0, 24'hFFFFFF, STATUS_STACK_FULL, 8'd0, 24'd0,
                 1'b0, 9'd256);
    // Largest slot: offset product near the top of the field
    add_setting(REG_ELEMENT_SIZE, 16'hFFFF);
    add_expected(ACTION_ALLOC, 16'hFFFF, 1'b0, 24'd0, STATUS_OK, 8'd255, 24'hFF0000, 1'b0, 9'd255);
    add_request(ACTION_FREE, 16'd0, 1'b0, 24'hFFFFFF);
    // Single slot pool, empty pool, foreign offset truncated to 8 bits
    add_setting(REG_ELEMENT_SIZE, 16'd1);
    add_setting(REG_ELEMENT_COUNT, 16'd1);
    add_expected(ACTION_ALLOC, 16'd1, 1'b0, 24'd0, STATUS_OK, 8'd0, 24'd0, 1'b0, 9'd0);
    add_expected(ACTION_ALLOC, 16'd1, 1'b0, 24'd0, STATUS_POOL_EMPTY, 8'd0, 24'd0, 1'b0, 9'd0);
    add_request(ACTION_FREE, 16'd0, 1'b0, 24'hFFFFFF);
    add_request(ACTION_ALLOC, 16'd1, 1'b0, 24'd0);
    // Zero slot size and a zero-slot pool
    add_setting(REG_ELEMENT_SIZE, 16'd0);
    add_setting(REG_ELEMENT_COUNT, 16'd0);
    add_expected(ACTION_ALLOC, 16'd0, 1'b0, 24'd0, STATUS_POOL_EMPTY, 8'd0, 24'd0, 1'b0, 9'd0);
    add_expected(ACTION_FREE, 16'd0, 1'b0, 24'd123, STATUS_STACK_FULL, 8'd0, 24'd0, 1'b0, 9'd0);
    add_setting(REG_ELEMENT_COUNT, 16'd4);
    add_expected(ACTION_ALLOC, 16'd0, 1'b0, 24'd0, STATUS_OK, 8'd3, 24'd0, 1'b0, 9'd3);
    add_request(ACTION_FREE, 16'd0, 1'b0, 24'd5);
    add_request(ACTION_ALLOC, 16'd0, 1'b0, 24'd0);
    // Smallest and largest overflow limits
    add_setting(REG_ELEMENT_SIZE, 16'd8);
    add_setting(REG_OVERFLOW_SIZE_LIMIT, 16'd1);
    add_request(ACTION_ALLOC, 16'd0, 1'b0, 24'd0);
    add_request(ACTION_FREE, 16'd0, 1'b1, 24'd0);
    add_expected(ACTION_ALLOC, 16'd1, 1'b0, 24'd0, STATUS_OVF_TOO_BIG, 8'd0, 24'd0, 1'b0, 9'd3);
    add_setting(REG_OVERFLOW_SIZE_LIMIT, 16'hFFFF);
    add_request(ACTION_ALLOC, 16'hFFFE, 1'b0, 24'd0);

    // Hold reset, then release it at a falling edge
    repeat (RST_CYCLES) @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        write_register(directed_rows[i].reg_idx, directed_rows[i].reg_val);
      end else begin
        send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].exp);
      end
    end

    // Random phases, each under its own configuration
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          sz = 16'd8;
          cnt = 9'd256;
          lim = 16'd256;
        end
        1: begin
          sz = 16'd1;
          cnt = 9'd1;
          lim = 16'd1;
        end
        2: begin
          sz = 16'hFFFF;
          cnt = 9'd256;
          lim = 16'hFFFF;
        end
        default: begin
          sz = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 200));
          cnt = 9'($urandom_range(1, 256));
          lim = 16'($urandom_range(1, 65535));
        end
      endcase
      write_register(REG_ELEMENT_SIZE, sz);
      write_register(REG_OVERFLOW_SIZE_LIMIT, lim);
      write_register(REG_ELEMENT_COUNT, 16'(cnt));
      no_idle = (ph == 2);
      drain_mode = 1'b1;
      repeat (RANDOM_ITEMS / PHASES) send_request(random_request(), 1'b0, '0);
    end
    no_idle = 1'b0;

    // Drain the remaining results, then settle
    s_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/fela_pkg.sv
rtl/core/fela_ram.sv
rtl/core/fela_datapath.sv
rtl/core/fela_ctrl.sv
rtl/core/fixed_element_free_list_allocator_core.sv
rtl/core/fela_checker.sv
dv/tb_top.sv
